// File: src/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

    // One table row holds the flags of this many slots.
    localparam int LANES  = 16;
    localparam int LANE_W = 4;

    localparam logic [1:0] ST_CREATED = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_YIELD  = 2'd1,
        CMD_RESUME = 2'd2,
        CMD_EXIT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_REFUSED = 2'd1,
        RES_IDLE    = 2'd2
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_RD,
        S_MOD_WR,
        S_SCAN_START,
        S_SCAN,
        S_DONE
    } state_t;

    typedef logic [LANES-1:0][1:0] lane_state_t;

    typedef struct packed {
        lane_state_t       st;
        logic [LANES-1:0]  in_use;
    } row_t;

    typedef struct packed {
        logic load;
        logic mod_read;
        logic mod_write;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t req_cmd;
        logic req_mark;
        logic req_target_ok;
        cmd_t cur_cmd;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/rrts_channels.sv
// Valid/ready channel interfaces for scheduler commands and results.
interface rrts_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       mark_waiting;
    logic [7:0] target_slot;

    modport source (output valid, cmd, mark_waiting, target_slot, input ready);
    modport sink   (input valid, cmd, mark_waiting, target_slot, output ready);
endinterface

interface rrts_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_code;
    logic [7:0] slot_id;
    logic       first_start;

    modport source (output valid, result_code, slot_id, first_start, input ready);
    modport sink   (input valid, result_code, slot_id, first_start, output ready);
endinterface

// File: src/rrts_ram.sv
// Generic simple dual-port RAM with registered read data.
module rrts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rrts_ctrl.sv
// Command sequencer of the scheduler: steps each transaction through the datapath.
module rrts_ctrl import rrts_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctrl.load = 1'b1;
                    unique case (status.req_cmd)
                        CMD_CREATE: state_next = S_SCAN_START;
                        CMD_YIELD:  state_next = status.req_mark ? S_MOD_RD : S_SCAN_START;
                        CMD_RESUME: state_next = status.req_target_ok ? S_MOD_RD : S_DONE;
                        CMD_EXIT:   state_next = S_MOD_RD;
                    endcase
                end
            end
            S_MOD_RD:
            begin
                ctrl.mod_read = 1'b1;
                state_next    = S_MOD_WR;
            end
            S_MOD_WR:
            begin
                ctrl.mod_write = 1'b1;
                state_next     = (status.cur_cmd == CMD_RESUME) ? S_DONE : S_SCAN_START;
            end
            S_SCAN_START:
            begin
                ctrl.scan_start = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (status.scan_hit || status.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (status.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> state_reg == S_IDLE)
        else $error("result load not followed by idle");

    a_resume_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_START |-> status.cur_cmd != CMD_RESUME)
        else $error("resume entered a scan");

endmodule

// File: src/rrts_datapath.sv
// Slot table, scan logic, current slot and result registers of the scheduler.
module rrts_datapath import rrts_pkg::*; #(
    parameter int SLOTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  ctrl,
    output dp_status_t status,
    input  logic [1:0] req_cmd,
    input  logic       req_mark,
    input  logic [7:0] req_target,
    rrts_rsp_if.source response
);

    localparam int ROWS = (SLOTS + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIW  = RW + LANE_W;
    localparam int IDW  = $clog2(SLOTS);
    localparam int CW   = $clog2(ROWS + 1);

    cmd_t               cmd_reg, cmd_next;
    logic [7:0]         target_reg, target_next;
    logic [IDW-1:0]     current_reg, current_next;
    logic [ROWS-1:0]    row_valid_reg, row_valid_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [RW-1:0]      scan_row_reg, scan_row_next;
    logic [CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [LANE_W-1:0]  start_lane_reg, start_lane_next;
    result_t            res_code_reg, res_code_next;
    logic [7:0]         res_id_reg, res_id_next;
    logic               res_first_reg, res_first_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_code_reg, out_code_next;
    logic [7:0]         out_id_reg, out_id_next;
    logic               out_first_reg, out_first_next;

    logic               wr_en;
    logic [RW-1:0]      wr_addr;
    row_t               wr_row;
    logic [RW-1:0]      rd_addr;
    logic [$bits(row_t)-1:0] rd_raw;
    row_t               row_data;

    logic [PIW-1:0]     mod_slot;
    logic [RW-1:0]      mod_row;
    logic [LANE_W-1:0]  mod_lane;
    logic [IDW-1:0]     sched_start;
    logic [PIW-1:0]     start_slot;
    logic [RW-1:0]      next_row;
    logic [LANES-1:0]   cand;
    logic               hit;
    logic [LANE_W-1:0]  hit_lane;
    logic [PIW-1:0]     hit_slot;
    logic               scan_last;
    logic               first;

    function automatic logic [7:0] to_id(input logic [PIW-1:0] s);
        logic [PIW+7:0] w;
        w = (PIW + 8)'(s);
        return w[7:0];
    endfunction

    rrts_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (ROWS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // rows never written read as all free, all created
    assign row_data = rd_valid_reg ? row_t'(rd_raw) : '0;

    assign mod_slot    = (cmd_reg == CMD_RESUME) ? PIW'(target_reg) : PIW'(current_reg);
    assign mod_row     = mod_slot[PIW-1:LANE_W];
    assign mod_lane    = mod_slot[LANE_W-1:0];
    assign sched_start = (current_reg == IDW'(SLOTS - 1)) ? '0 : IDW'(current_reg + 1'b1);
    assign start_slot  = (cmd_reg == CMD_CREATE) ? '0 : PIW'(sched_start);
    assign next_row    = (scan_row_reg == RW'(ROWS - 1)) ? '0 : RW'(scan_row_reg + 1'b1);
    assign scan_last   = (scan_cnt_reg == CW'(ROWS));
    assign hit_slot    = {scan_row_reg, hit_lane};
    assign first       = (row_data.st[hit_lane] == ST_CREATED);

    // Lanes that qualify in the row under scan. The first pass over the start
    // row takes lanes from the start lane up, the closing pass the lanes below.
    always_comb
    begin
        logic [PIW-1:0] lane_slot;
        logic           in_range;
        logic           lo_ok;
        logic           hi_ok;
        logic           want;
        for (int l = 0; l < LANES; l++)
        begin
            lane_slot = {scan_row_reg, LANE_W'(l)};
            in_range  = int'(lane_slot) < SLOTS;
            lo_ok     = (scan_cnt_reg != '0) || (LANE_W'(l) >= start_lane_reg);
            hi_ok     = !scan_last || (LANE_W'(l) < start_lane_reg);
            if (cmd_reg == CMD_CREATE)
            begin
                want = !row_data.in_use[l];
            end
            else
            begin
                want = row_data.in_use[l] && (row_data.st[l] != ST_WAITING);
            end
            cand[l] = in_range && lo_ok && hi_ok && want;
        end
    end

    always_comb
    begin
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (cand[l])
            begin
                hit_lane = LANE_W'(l);
            end
        end
    end

    assign hit = |cand;

    always_comb
    begin
        priority if (ctrl.mod_read)
        begin
            rd_addr = mod_row;
        end
        else if (ctrl.scan_start)
        begin
            rd_addr = start_slot[PIW-1:LANE_W];
        end
        else
        begin
            rd_addr = next_row;
        end
    end

    assign rd_valid_next = row_valid_reg[rd_addr];

    always_comb
    begin
        cmd_next        = cmd_reg;
        target_next     = target_reg;
        current_next    = current_reg;
        row_valid_next  = row_valid_reg;
        scan_row_next   = scan_row_reg;
        scan_cnt_next   = scan_cnt_reg;
        start_lane_next = start_lane_reg;
        res_code_next   = res_code_reg;
        res_id_next     = res_id_reg;
        res_first_next  = res_first_reg;
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_id_next     = out_id_reg;
        out_first_next  = out_first_reg;
        wr_en           = 1'b0;
        wr_addr         = mod_row;
        wr_row          = row_data;

        if (ctrl.load)
        begin
            cmd_next       = cmd_t'(req_cmd);
            target_next    = req_target;
            // a resume outside the table finishes with this result
            res_code_next  = RES_REFUSED;
            res_id_next    = req_target;
            res_first_next = 1'b0;
        end

        if (ctrl.mod_write)
        begin
            unique case (cmd_reg)
                CMD_YIELD:
                begin
                    wr_row.st[mod_lane] = ST_WAITING;
                    wr_en               = 1'b1;
                end
                CMD_EXIT:
                begin
                    wr_row.in_use[mod_lane] = 1'b0;
                    wr_en                   = 1'b1;
                    current_next            = '0;
                end
                CMD_RESUME:
                begin
                    if (row_data.in_use[mod_lane])
                    begin
                        wr_row.st[mod_lane] = ST_RUNNING;
                        wr_en               = 1'b1;
                        res_code_next       = RES_OK;
                    end
                end
                CMD_CREATE:
                begin
                end
            endcase
        end

        if (ctrl.scan_start)
        begin
            scan_row_next   = start_slot[PIW-1:LANE_W];
            start_lane_next = start_slot[LANE_W-1:0];
            scan_cnt_next   = '0;
        end

        if (ctrl.scan_step)
        begin
            if (hit)
            begin
                wr_en       = 1'b1;
                wr_addr     = scan_row_reg;
                res_code_next = RES_OK;
                res_id_next   = to_id(hit_slot);
                if (cmd_reg == CMD_CREATE)
                begin
                    wr_row.in_use[hit_lane] = 1'b1;
                    wr_row.st[hit_lane]     = ST_CREATED;
                    res_first_next          = 1'b0;
                end
                else
                begin
                    if (first)
                    begin
                        wr_row.st[hit_lane] = ST_RUNNING;
                    end
                    current_next   = IDW'(hit_slot);
                    res_first_next = first;
                end
            end
            else if (scan_last)
            begin
                res_first_next = 1'b0;
                if (cmd_reg == CMD_CREATE)
                begin
                    res_code_next = RES_REFUSED;
                    res_id_next   = '0;
                end
                else
                begin
                    res_code_next = RES_IDLE;
                    res_id_next   = to_id(PIW'(current_reg));
                end
            end
            else
            begin
                scan_row_next = next_row;
                scan_cnt_next = CW'(scan_cnt_reg + 1'b1);
            end
        end

        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end

        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            out_code_next  = res_code_reg;
            out_id_next    = res_id_reg;
            out_first_next = res_first_reg;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg   <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_CREATE;
        end
        else
        begin
            current_reg   <= current_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        rd_valid_reg   <= rd_valid_next;
        scan_row_reg   <= scan_row_next;
        scan_cnt_reg   <= scan_cnt_next;
        start_lane_reg <= start_lane_next;
        res_code_reg   <= res_code_next;
        res_id_reg     <= res_id_next;
        res_first_reg  <= res_first_next;
        out_code_reg   <= out_code_next;
        out_id_reg     <= out_id_next;
        out_first_reg  <= out_first_next;
    end

    assign response.valid       = out_valid_reg;
    assign response.result_code = out_code_reg;
    assign response.slot_id     = out_id_reg;
    assign response.first_start = out_first_reg;

    assign status.req_cmd       = cmd_t'(req_cmd);
    assign status.req_mark      = req_mark;
    assign status.req_target_ok = int'(req_target) < SLOTS;
    assign status.cur_cmd       = cmd_reg;
    assign status.scan_hit      = hit;
    assign status.scan_last     = scan_last;
    assign status.out_free      = !out_valid_reg || response.ready;

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.scan_step |-> scan_cnt_reg <= CW'(ROWS))
        else $error("scan ran past the closing pass");

    a_current_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        int'(current_reg) < SLOTS)
        else $error("current slot outside the table");

    a_no_write_on_mod_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mod_read |-> !wr_en)
        else $error("table write during a row fetch");

endmodule

// File: src/round_robin_task_scheduler.sv
// Round-robin task scheduler: slot table with create, yield, resume and exit.
// One command transaction is handled at a time. The slot table sits in a RAM of
// SLOTS/16 rows (rounded up), each row carrying the in-use flags and states of 16
// slots, and free-slot and runnable-slot searches read one row per cycle. A
// create, or a yield without the waiting mark, goes straight to the search; it
// reads rows up to and including the match, at most one more than the row count
// (17 for 256 slots), and then offers its result. A yield with the waiting mark
// and an exit first do a read-modify-write of the current slot's row. A resume
// does a read-modify-write of the target's row and no search, or goes straight
// to its result when the target lies outside the table. The result waits until
// the output register is free. The next command is accepted from the same cycle
// in which the result is offered. A new command is taken while the previous result
// still waits in the output register. No clearing pass follows reset: per-row
// valid flags make untouched rows read as free.
module round_robin_task_scheduler import rrts_pkg::*; #(
    parameter int SLOTS = 256
) (
    input logic       clk,
    input logic       rst_n,
    rrts_req_if.sink  request,
    rrts_rsp_if.source response
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;
    logic       req_ready;

    assign request.ready = req_ready;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    rrts_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .req_cmd    (request.cmd),
        .req_mark   (request.mark_waiting),
        .req_target (request.target_slot),
        .response   (response)
    );

endmodule
